// ===== hw/rtl/typea_anticollision_uid_resolver_macros.svh =====
// assertion helpers used by the resolver top module
`ifndef TYPEA_ANTICOLLISION_UID_RESOLVER_MACROS_SVH
`define TYPEA_ANTICOLLISION_UID_RESOLVER_MACROS_SVH

// same-cycle implication, off during reset
`define TACUR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TACUR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tacur_pkg.sv =====
// ----------------------------------------------------------------------------
// tacur_pkg
// types, codes and constants of the type A anticollision uid resolver
// ----------------------------------------------------------------------------
package tacur_pkg;

   localparam int UID_LEN = 5;

   // request kind
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // reply status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TIMEOUT   = 2'd1;
   localparam logic [1:0] ST_COLLISION = 2'd2;
   localparam logic [1:0] ST_OTHER     = 2'd3;

   // outcome
   localparam logic [1:0] OUT_NEXT  = 2'd0;
   localparam logic [1:0] OUT_DONE  = 2'd1;
   localparam logic [1:0] OUT_ERROR = 2'd2;

   localparam logic [6:0] NVB_START = 7'h20;
   localparam logic [6:0] NVB_FULL  = 7'h58;
   localparam logic [2:0] FULL_UID_BYTES  = 3'd5;
   localparam logic [2:0] FULL_KNOWN      = 3'd4;
   localparam logic [3:0] FRAME_UID_TOTAL = 4'd6;

   typedef struct packed {
      logic                      kind;
      logic [7:0]                select_code;
      logic [1:0]                reply_status;
      logic [4:0]                collision_position;
      logic [5:0]                received_bits;
      logic [UID_LEN-1:0][7:0]   rx;
   } req_type;

   typedef struct packed {
      logic [UID_LEN-1:0][7:0]   uid;
      logic [6:0]                nvb;
      logic [6:0]                framing;
      logic [7:0]                mask;
      logic [2:0]                known;
      logic [7:0]                sel;
   } state_type;

   typedef struct packed {
      logic [1:0]                outcome;
      logic [7:0]                frame_select;
      logic [6:0]                frame_nvb;
      logic [6:0]                frame_bit_framing;
      logic [2:0]                frame_length;
      logic [UID_LEN-1:0][7:0]   uid;
   } rsp_type;

   localparam state_type STATE_RESET = '{
      uid:     '0,
      nvb:     NVB_START,
      framing: 7'd0,
      mask:    8'd0,
      known:   3'd0,
      sel:     8'd0
   };

endpackage

// ===== hw/rtl/tacur_in_reg.sv =====
// ----------------------------------------------------------------------------
// tacur_in_reg
// input register: holds one request until the step logic moves it on
// ----------------------------------------------------------------------------
module tacur_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tacur_pkg::req_type req_in,
   input  logic              advance,
   output logic              hold_valid,
   output tacur_pkg::req_type hold_req
);
   import tacur_pkg::*;

   logic    valid_ff, valid_in;
   req_type req_ff, req_nx_in;

   assign req_ready  = !valid_ff || advance;
   assign hold_valid = valid_ff;
   assign hold_req   = req_ff;

   always_comb begin
      valid_in  = valid_ff;
      req_nx_in = req_ff;
      if (req_ready) begin
         valid_in  = req_valid;
         req_nx_in = req_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_nx_in;
   end

endmodule

// ===== hw/rtl/tacur_step.sv =====
// ----------------------------------------------------------------------------
// tacur_step
// next state and result for one request: start, timeout, collision split, merge, bcc check
// ----------------------------------------------------------------------------
module tacur_step (
   input  tacur_pkg::req_type   req,
   input  tacur_pkg::state_type cur,
   output tacur_pkg::state_type nxt,
   output tacur_pkg::rsp_type   rsp
);
   import tacur_pkg::*;

   logic [1:0] outcome;
   logic [4:0] pos_m1;
   logic [1:0] grp;
   logic [3:0] off;
   logic [7:0] frm_wide;
   logic [2:0] low;
   logic [7:0] new_mask;
   logic [2:0] len;
   logic [2:0] src;
   logic [7:0] b;
   logic [7:0] bcc;
   logic       len_ok;
   state_type  upd;

   always_comb begin
      upd      = cur;
      outcome  = OUT_NEXT;
      pos_m1   = req.collision_position - 5'd1;
      grp      = pos_m1[4:3];
      off      = {1'b0, pos_m1[2:0]} + 4'd1;
      frm_wide = {off, 4'b0000} + {4'b0000, off};
      len      = (req.received_bits > 6'd8) ? req.received_bits[5:3] : 3'd1;
      len_ok   = 1'b0;
      low      = 3'd0;
      new_mask = 8'd0;
      src      = 3'd0;
      b        = 8'd0;
      bcc      = 8'd0;

      if (req.kind == KIND_START) begin
         upd     = STATE_RESET;
         upd.sel = req.select_code;
      end else begin
         case (req.reply_status)
            ST_TIMEOUT: begin
               outcome = OUT_ERROR;
            end
            ST_COLLISION: begin
               if (req.collision_position == 5'd0) begin
                  upd.nvb     = NVB_FULL;
                  upd.known   = FULL_KNOWN;
                  upd.framing = 7'd0;
               end else begin
                  upd.nvb     = NVB_START + {1'b0, grp, 4'b0000} + {3'b000, off};
                  upd.known   = {1'b0, grp} + 3'd1;
                  upd.framing = frm_wide[6:0];
               end
               // on a byte boundary the old mask stays
               low = upd.nvb[2:0];
               for (int i = 0; i < 8; i++) begin
                  new_mask[i] = (3'(i) < low);
               end
               if (low != 3'd0) begin
                  upd.mask = new_mask;
               end
               for (int i = 0; i < UID_LEN; i++) begin
                  b = req.rx[i];
                  if (3'(i) == upd.known - 3'd1) begin
                     b = b & upd.mask;
                  end
                  if (3'(i) < upd.known) begin
                     upd.uid[i] = cur.uid[i] | b;
                  end
               end
               outcome = OUT_NEXT;
            end
            default: begin
               if (cur.known == 3'd0) begin
                  len_ok = (len == FULL_UID_BYTES);
                  if (len_ok) begin
                     upd.uid = req.rx;
                  end
               end else begin
                  len_ok = (cur.known <= FULL_KNOWN) &&
                           (({1'b0, len} + {1'b0, cur.known}) == FRAME_UID_TOTAL);
                  if (len_ok) begin
                     // received byte 0 lands on the partly known byte
                     for (int j = 0; j < UID_LEN; j++) begin
                        src = 3'(j) - cur.known + 3'd1;
                        if (3'(j) >= cur.known - 3'd1 && src < 3'(UID_LEN)) begin
                           upd.uid[j] = cur.uid[j] | req.rx[src];
                        end
                     end
                  end
               end
               bcc = upd.uid[0] ^ upd.uid[1] ^ upd.uid[2] ^ upd.uid[3];
               if (!len_ok) begin
                  upd     = cur;
                  outcome = OUT_ERROR;
               end else if (upd.uid[4] == bcc) begin
                  outcome = OUT_DONE;
               end else begin
                  outcome = OUT_ERROR;
               end
            end
         endcase
      end

      nxt                   = upd;
      rsp.outcome           = outcome;
      rsp.frame_select      = upd.sel;
      rsp.frame_nvb         = upd.nvb;
      rsp.frame_bit_framing = upd.framing;
      rsp.frame_length      = upd.known + 3'd2;
      rsp.uid               = upd.uid;
   end

endmodule

// ===== hw/rtl/typea_anticollision_uid_resolver.sv =====
// ----------------------------------------------------------------------------
// typea_anticollision_uid_resolver
// reader side of one type A anticollision cascade level
//
//   channel   dir   payload                                      accepted when
//   req_      in    kind, select, status, position, bits, rx[5]  req_valid & req_ready
//   rsp_      out   outcome, select, nvb, framing, length, uid   rsp_valid & rsp_ready
//
// one request per cycle while no result is stalled; each request waits in the input
// register until the step takes it, and its result is registered as the level state updates
// the state update is the only loop, closed through the level state register edge
// reset clears the level state to nvb 0x20 with an empty uid, and both stages
// a stalled result holds the step; the input register still takes one request
// ----------------------------------------------------------------------------
`include "typea_anticollision_uid_resolver_macros.svh"

module typea_anticollision_uid_resolver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_select_code,
   input  logic [1:0] req_reply_status,
   input  logic [4:0] req_collision_position,
   input  logic [5:0] req_received_bits,
   input  logic [7:0] req_rx_byte_0,
   input  logic [7:0] req_rx_byte_1,
   input  logic [7:0] req_rx_byte_2,
   input  logic [7:0] req_rx_byte_3,
   input  logic [7:0] req_rx_byte_4,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_outcome,
   output logic [7:0] rsp_frame_select,
   output logic [6:0] rsp_frame_nvb,
   output logic [6:0] rsp_frame_bit_framing,
   output logic [2:0] rsp_frame_length,
   output logic [7:0] rsp_uid_out_0,
   output logic [7:0] rsp_uid_out_1,
   output logic [7:0] rsp_uid_out_2,
   output logic [7:0] rsp_uid_out_3,
   output logic [7:0] rsp_uid_out_4
);
   import tacur_pkg::*;

   req_type   req_bus;
   req_type   hold_req;
   logic      hold_valid;
   logic      advance;
   state_type state_ff, state_in;
   rsp_type   rsp_ff, rsp_in, step_rsp;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      req_bus.kind               = req_kind;
      req_bus.select_code        = req_select_code;
      req_bus.reply_status       = req_reply_status;
      req_bus.collision_position = req_collision_position;
      req_bus.received_bits      = req_received_bits;
      req_bus.rx[0]              = req_rx_byte_0;
      req_bus.rx[1]              = req_rx_byte_1;
      req_bus.rx[2]              = req_rx_byte_2;
      req_bus.rx[3]              = req_rx_byte_3;
      req_bus.rx[4]              = req_rx_byte_4;
   end

   assign advance = !rsp_valid_ff || rsp_ready;

   tacur_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in     (req_bus),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_req   (hold_req)
   );

   state_type step_nxt;

   tacur_step u_step (
      .req (hold_req),
      .cur (state_ff),
      .nxt (step_nxt),
      .rsp (step_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = hold_valid;
         if (hold_valid) begin
            state_in = step_nxt;
            rsp_in   = step_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_outcome           = rsp_ff.outcome;
   assign rsp_frame_select      = rsp_ff.frame_select;
   assign rsp_frame_nvb         = rsp_ff.frame_nvb;
   assign rsp_frame_bit_framing = rsp_ff.frame_bit_framing;
   assign rsp_frame_length      = rsp_ff.frame_length;
   assign rsp_uid_out_0         = rsp_ff.uid[0];
   assign rsp_uid_out_1         = rsp_ff.uid[1];
   assign rsp_uid_out_2         = rsp_ff.uid[2];
   assign rsp_uid_out_3         = rsp_ff.uid[3];
   assign rsp_uid_out_4         = rsp_ff.uid[4];

   `TACUR_ASSERT_NXT(a_step_fills_rsp, clock, reset, hold_valid && advance, rsp_valid, "request lost between stages")
   `TACUR_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_ready, hold_valid && rsp_valid && !rsp_ready, "request stalled without cause")
   `TACUR_ASSERT_NXT(a_start_clears_level, clock, reset, hold_valid && advance && hold_req.kind == KIND_START, state_ff.known == 3'd0 && state_ff.nvb == NVB_START && state_ff.uid == '0, "start did not clear the level")
   `TACUR_ASSERT_IMP(a_done_has_good_bcc, clock, reset, rsp_valid && rsp_outcome == OUT_DONE, rsp_uid_out_4 == (rsp_uid_out_0 ^ rsp_uid_out_1 ^ rsp_uid_out_2 ^ rsp_uid_out_3), "done reported with a bad bcc")

endmodule

// ===== dv/typea_anticollision_uid_resolver_tb.sv =====
// ----------------------------------------------------------------------------
// typea_anticollision_uid_resolver_tb
// self-checking bench for the type A anticollision cascade level resolver:
// a directed walk over frame extremes, length errors and every collision
// group, then whole cascade levels built around a chosen uid, mixed with
// random requests, under random gaps on the request side and random stalls
// on the response side
// ----------------------------------------------------------------------------
module typea_anticollision_uid_resolver_tb;

   import tacur_pkg::*;

   localparam logic [6:0] NVB_GROUP_STEP = 7'h10;
   localparam int         RANDOM_TARGET  = 1450;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } plan_row;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_kind;
   logic [7:0] req_select_code;
   logic [1:0] req_reply_status;
   logic [4:0] req_collision_position;
   logic [5:0] req_received_bits;
   logic [7:0] req_rx_byte_0;
   logic [7:0] req_rx_byte_1;
   logic [7:0] req_rx_byte_2;
   logic [7:0] req_rx_byte_3;
   logic [7:0] req_rx_byte_4;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_outcome;
   logic [7:0] rsp_frame_select;
   logic [6:0] rsp_frame_nvb;
   logic [6:0] rsp_frame_bit_framing;
   logic [2:0] rsp_frame_length;
   logic [7:0] rsp_uid_out_0;
   logic [7:0] rsp_uid_out_1;
   logic [7:0] rsp_uid_out_2;
   logic [7:0] rsp_uid_out_3;
   logic [7:0] rsp_uid_out_4;

   state_type level;
   rsp_type   pending_frames[$];
   plan_row   plan[$];
   bit        row_typed;
   rsp_type   row_want;
   bit        steady;
   int        sent;
   int        mismatches;
   rsp_type   got_frame;
   rsp_type   due_frame;

   typea_anticollision_uid_resolver u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic note_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h, want %0h", what, got, want);
      mismatches++;
   endtask

   function automatic void clear_level(logic [7:0] sel);
      level.uid     = '0;
      level.nvb     = NVB_START;
      level.framing = 7'd0;
      level.mask    = 8'd0;
      level.known   = 3'd0;
      level.sel     = sel;
   endfunction

   // frame the resolver owes for one request, with the level state advanced
   function automatic rsp_type advance_level(req_type r);
      rsp_type    f;
      logic [1:0] verdict;
      logic [7:0] b;
      int         pos, grp, off, len, cnt;
      verdict = OUT_NEXT;
      if (r.kind == KIND_START) begin
         clear_level(r.select_code);
      end else begin
         case (r.reply_status)
            ST_TIMEOUT: verdict = OUT_ERROR;
            ST_COLLISION: begin
               pos = int'(r.collision_position);
               if (pos == 0) begin
                  // zero stands for position 32, all four bytes known
                  level.nvb     = NVB_FULL;
                  level.known   = FULL_KNOWN;
                  level.framing = 7'd0;
               end else begin
                  grp           = (pos - 1) >> 3;
                  off           = pos - 8 * grp;
                  level.nvb     = NVB_START + NVB_GROUP_STEP * 7'(grp) + 7'(off);
                  level.known   = 3'(grp + 1);
                  level.framing = 7'((off << 4) + off);
               end
               // byte boundary keeps the old mask
               if (level.nvb[2:0] != 3'd0)
                  level.mask = 8'((1 << level.nvb[2:0]) - 1);
               for (int i = 0; i < level.known; i++) begin
                  b = r.rx[i];
                  if (i == level.known - 1)
                     b = b & level.mask;
                  level.uid[i] = level.uid[i] | b;
               end
            end
            default: begin
               len = (r.received_bits > 6'd8) ? int'(r.received_bits >> 3) : 1;
               cnt = int'(level.known);
               if (cnt == 0) begin
                  if (len != int'(FULL_UID_BYTES))
                     verdict = OUT_ERROR;
                  else
                     level.uid = r.rx;
               end else if (cnt > int'(FULL_KNOWN) || len + cnt != int'(FRAME_UID_TOTAL)) begin
                  verdict = OUT_ERROR;
               end else begin
                  for (int i = 0; i < len; i++)
                     level.uid[i + cnt - 1] = level.uid[i + cnt - 1] | r.rx[i];
               end
               if (verdict == OUT_NEXT)
                  verdict = (level.uid[4] == (level.uid[0] ^ level.uid[1] ^ level.uid[2] ^
                             level.uid[3])) ? OUT_DONE : OUT_ERROR;
            end
         endcase
      end
      f.outcome           = verdict;
      f.frame_select      = level.sel;
      f.frame_nvb         = level.nvb;
      f.frame_bit_framing = level.framing;
      f.frame_length      = level.known + 3'd2;
      f.uid               = level.uid;
      return f;
   endfunction

   function automatic void add_row(req_type r, bit typed = 1'b0, rsp_type want = '0);
      plan_row row;
      row.r     = r;
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.kind               = 1'($urandom_range(1));
      r.select_code        = 8'($urandom_range(255));
      r.reply_status       = 2'($urandom_range(3));
      r.collision_position = 5'($urandom_range(31));
      r.received_bits      = 6'($urandom_range(40));
      r.rx                 = {$urandom(), 8'($urandom())};
      return r;
   endfunction

   task automatic send(req_type r, bit typed = 1'b0, rsp_type want = '0);
      while (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_kind               <= r.kind;
      req_select_code        <= r.select_code;
      req_reply_status       <= r.reply_status;
      req_collision_position <= r.collision_position;
      req_received_bits      <= r.received_bits;
      req_rx_byte_0          <= r.rx[0];
      req_rx_byte_1          <= r.rx[1];
      req_rx_byte_2          <= r.rx[2];
      req_rx_byte_3          <= r.rx[3];
      req_rx_byte_4          <= r.rx[4];
      row_typed              <= typed;
      row_want               <= want;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      sent++;
   endtask

   // one cascade level around a chosen uid: start, up to three collision or timeout replies, final reply
   task automatic run_cascade();
      logic [UID_LEN-1:0][7:0] target;
      req_type                 r;
      int                      cnt, len;
      for (int i = 0; i < 4; i++)
         target[i] = 8'($urandom_range(255));
      target[4] = target[0] ^ target[1] ^ target[2] ^ target[3];
      if ($urandom_range(99) < 15)
         target[4] = target[4] ^ 8'($urandom_range(1, 255));
      r = random_request();
      r.kind = KIND_START;
      send(r);
      repeat ($urandom_range(3)) begin
         r = random_request();
         r.kind = KIND_REPLY;
         r.reply_status = ($urandom_range(99) < 10) ? ST_TIMEOUT : ST_COLLISION;
         r.rx = target;
         send(r);
      end
      r = random_request();
      r.kind = KIND_REPLY;
      r.reply_status = $urandom_range(1) ? ST_OK : ST_OTHER;
      cnt = int'(level.known);
      if (cnt == 0) begin
         r.received_bits = 6'd40;
         r.rx = target;
      end else begin
         len = 6 - cnt;
         r.received_bits = 6'(len * 8 + $urandom_range(len == 5 ? 0 : 7));
         for (int i = 0; i < len; i++)
            r.rx[i] = target[i + cnt - 1];
      end
      if ($urandom_range(99) < 10)
         r.received_bits = 6'($urandom_range(40));
      send(r);
   endtask

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            due_frame = advance_level({req_kind, req_select_code, req_reply_status,
                                       req_collision_position, req_received_bits,
                                       req_rx_byte_4, req_rx_byte_3, req_rx_byte_2,
                                       req_rx_byte_1, req_rx_byte_0});
            pending_frames.push_back(row_typed ? row_want : due_frame);
         end
         if (rsp_valid && rsp_ready) begin
            got_frame = {rsp_outcome, rsp_frame_select, rsp_frame_nvb, rsp_frame_bit_framing,
                         rsp_frame_length, rsp_uid_out_4, rsp_uid_out_3, rsp_uid_out_2,
                         rsp_uid_out_1, rsp_uid_out_0};
            if (pending_frames.size() == 0) begin
               note_mismatch("response with none outstanding, outcome", got_frame.outcome, 0);
            end else begin
               due_frame = pending_frames.pop_front();
               if (got_frame.outcome != due_frame.outcome)
                  note_mismatch("outcome", got_frame.outcome, due_frame.outcome);
               if (got_frame.frame_select != due_frame.frame_select)
                  note_mismatch("frame_select", got_frame.frame_select, due_frame.frame_select);
               if (got_frame.frame_nvb != due_frame.frame_nvb)
                  note_mismatch("frame_nvb", got_frame.frame_nvb, due_frame.frame_nvb);
               if (got_frame.frame_bit_framing != due_frame.frame_bit_framing)
                  note_mismatch("frame_bit_framing", got_frame.frame_bit_framing,
                                due_frame.frame_bit_framing);
               if (got_frame.frame_length != due_frame.frame_length)
                  note_mismatch("frame_length", got_frame.frame_length, due_frame.frame_length);
               for (int i = 0; i < UID_LEN; i++)
                  if (got_frame.uid[i] != due_frame.uid[i])
                     note_mismatch($sformatf("uid_out_%0d", i), got_frame.uid[i],
                                   due_frame.uid[i]);
            end
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      req_valid              = 1'b0;
      req_kind               = KIND_START;
      req_select_code        = 8'd0;
      req_reply_status       = ST_OK;
      req_collision_position = 5'd0;
      req_received_bits      = 6'd0;
      req_rx_byte_0          = 8'd0;
      req_rx_byte_1          = 8'd0;
      req_rx_byte_2          = 8'd0;
      req_rx_byte_3          = 8'd0;
      req_rx_byte_4          = 8'd0;
      row_typed              = 1'b0;
      row_want               = '0;
      steady                 = 1'b0;
      sent                   = 0;
      mismatches             = 0;
      clear_level(8'h00);

      // request fields: kind, select, status, position, bits, rx byte 4 down to byte 0
      // response fields: outcome, select, nvb, framing, length, uid byte 4 down to byte 0
      add_row({KIND_START, 8'h93, ST_OK, 5'd0, 6'd0, 40'h0}, 1'b1,
              {OUT_NEXT, 8'h93, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_REPLY, 8'h00, ST_TIMEOUT, 5'd0, 6'd0, 40'h0}, 1'b1,
              {OUT_ERROR, 8'h93, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_REPLY, 8'h00, ST_OK, 5'd0, 6'd40, 40'h44_44332211});
      add_row({KIND_REPLY, 8'h00, ST_OK, 5'd0, 6'd40, 40'hFF_FFFFFFFF});
      add_row({KIND_START, 8'hFF, ST_OK, 5'd0, 6'd0, 40'h0}, 1'b1,
              {OUT_NEXT, 8'hFF, NVB_START, 7'h00, 3'd2, 40'h0});
      // short replies with nothing known are length errors
      add_row({KIND_REPLY, 8'h00, ST_OK, 5'd0, 6'd0, 40'h12_34567890}, 1'b1,
              {OUT_ERROR, 8'hFF, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_REPLY, 8'h00, ST_OK, 5'd0, 6'd8, 40'h12_34567890}, 1'b1,
              {OUT_ERROR, 8'hFF, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_REPLY, 8'h00, ST_OTHER, 5'd0, 6'd39, 40'h12_34567890}, 1'b1,
              {OUT_ERROR, 8'hFF, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_START, 8'h00, ST_OK, 5'd0, 6'd0, 40'h0}, 1'b1,
              {OUT_NEXT, 8'h00, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd0, 6'd32, 40'hFF_FFFFFFFF});
      add_row({KIND_REPLY, 8'h00, ST_OK, 5'd0, 6'd16, 40'h00_00005AC3});
      add_row({KIND_START, 8'h95, ST_OK, 5'd0, 6'd0, 40'h0}, 1'b1,
              {OUT_NEXT, 8'h95, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd1, 6'd1, 40'hA5_A5A5A5A5});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd8, 6'd8, 40'h5A_5A5A5A5A});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd13, 6'd13, 40'h0F_0F0F0F0F});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd16, 6'd16, 40'hF0_F0F0F0F0});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd24, 6'd24, 40'h3C_3C3C3C3C});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd31, 6'd31, 40'hC3_C3C3C3C3});
      add_row({KIND_REPLY, 8'h00, ST_OTHER, 5'd0, 6'd23, 40'h00_00009966});
      // no lock after a verdict, the next reply is merged again
      add_row({KIND_REPLY, 8'h00, ST_OK, 5'd0, 6'd16, 40'h00_00000101});
      add_row({KIND_START, 8'h97, ST_OK, 5'd0, 6'd0, 40'h0}, 1'b1,
              {OUT_NEXT, 8'h97, NVB_START, 7'h00, 3'd2, 40'h0});
      add_row({KIND_REPLY, 8'h00, ST_COLLISION, 5'd5, 6'd5, 40'hFF_FFFFFF3F});
      add_row({KIND_REPLY, 8'h00, ST_OK, 5'd0, 6'd40, 40'h5D_4C3B2A00});
      add_row({KIND_REPLY, 8'hFF, ST_TIMEOUT, 5'h1F, 6'd40, 40'hFF_FFFFFFFF});

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send(plan[i].r, plan[i].typed, plan[i].want);

      while (sent < RANDOM_TARGET) begin
         steady = (sent >= 600 && sent < 850);
         if ($urandom_range(99) < 75)
            run_cascade();
         else
            send(random_request());
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      for (int w = 0; w < 2000 && pending_frames.size() != 0; w++)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_frames.size() != 0)
         note_mismatch("responses never seen, count", pending_frames.size(), 0);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tacur_pkg.sv
hw/rtl/tacur_in_reg.sv
hw/rtl/tacur_step.sv
hw/rtl/typea_anticollision_uid_resolver.sv
dv/typea_anticollision_uid_resolver_tb.sv
